// ===== hw/rtl/polyhedron_face_and_motion_detector_assert.svh =====
// Assertion macros for the face and motion detector.
`ifndef POLYHEDRON_FACE_AND_MOTION_DETECTOR_ASSERT_SVH
`define POLYHEDRON_FACE_AND_MOTION_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// check after reset is released
`define PFMD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfmd assertion failed");
// check in every cycle, reset included
`define PFMD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("pfmd assertion failed");
`else
`define PFMD_ASSERT(label, prop)
`define PFMD_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hw/rtl/pfmd_pkg.sv =====
package pfmd_pkg;

  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned THRESH_W    = 17;
  localparam int unsigned LABEL_W     = 4;
  localparam int unsigned BEST_W      = 16;
  localparam int unsigned COEF_W      = 8;
  localparam int unsigned PROD_W      = AXIS_W + COEF_W;
  localparam int unsigned SCORE_SHIFT = 7;
  localparam int unsigned TERM_W      = PROD_W - SCORE_SHIFT;
  localparam int unsigned SCORE_W     = TERM_W + 2;
  localparam int unsigned MAG_W       = AXIS_W + 1;

  localparam int unsigned FILTER_SHIFT  = 3;
  localparam int unsigned FILTER_WEIGHT = 1 << FILTER_SHIFT;
  localparam int unsigned FILTER_NUM_W  = AXIS_W + FILTER_SHIFT + 1;

  localparam int unsigned FACE_COUNT = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(2000);

  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [LABEL_W-1:0]        label_t;
  typedef logic [THRESH_W-1:0]       thresh_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] rate_x;
    logic signed [AXIS_W-1:0] rate_y;
    logic signed [AXIS_W-1:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic [LABEL_W-1:0] face_label;
    logic [BEST_W-1:0]  best_score;
    logic               still;
  } result_t;

  localparam logic signed [COEF_W-1:0] FACE_CX [FACE_COUNT] = '{
    8'sd0, 8'sd85, 8'sd26, -8'sd69, -8'sd69, 8'sd26,
    8'sd69, -8'sd26, -8'sd85, -8'sd26, 8'sd69, 8'sd0
  };
  localparam logic signed [COEF_W-1:0] FACE_CY [FACE_COUNT] = '{
    8'sd0, 8'sd0, 8'sd81, 8'sd50, -8'sd50, -8'sd81,
    8'sd50, 8'sd81, 8'sd0, -8'sd81, -8'sd50, 8'sd0
  };
  localparam logic signed [COEF_W-1:0] FACE_CZ [FACE_COUNT] = '{
    8'sd100, 8'sd53, 8'sd53, 8'sd53, 8'sd53, 8'sd53,
    -8'sd53, -8'sd53, -8'sd53, -8'sd53, -8'sd53, -8'sd100
  };
  localparam label_t FACE_LABEL [FACE_COUNT] = '{
    4'd11, 4'd10, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd4, 4'd5, 4'd1, 4'd2, 4'd3, 4'd0
  };

  // new = (sample + (W-1)*old) / W, truncated toward zero
  function automatic axis_t smooth(input axis_t old_avg, input axis_t sample);
    logic signed [FILTER_NUM_W-1:0] num;
    logic signed [FILTER_NUM_W-1:0] bias;
    logic signed [FILTER_NUM_W-1:0] quo;
    num  = FILTER_NUM_W'(sample)
         + FILTER_NUM_W'(old_avg) * $signed(FILTER_NUM_W'(FILTER_WEIGHT - 1));
    bias = num[FILTER_NUM_W-1] ? $signed(FILTER_NUM_W'(FILTER_WEIGHT - 1))
                               : '0;
    quo  = (num + bias) >>> FILTER_SHIFT;
    return quo[AXIS_W-1:0];
  endfunction

  // product / 128, truncated toward zero
  function automatic logic signed [TERM_W-1:0] scale_term(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] quo;
    bias = prod[PROD_W-1] ? $signed(PROD_W'((1 << SCORE_SHIFT) - 1)) : '0;
    quo  = (prod + bias) >>> SCORE_SHIFT;
    return quo[TERM_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input axis_t v);
    logic signed [MAG_W-1:0] ext;
    ext = MAG_W'(v);
    return ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
  endfunction

endpackage

// ===== hw/rtl/pfmd_if.sv =====
interface pfmd_sample_if;
  import pfmd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfmd_result_if;
  import pfmd_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfmd_cfg_if;
  import pfmd_pkg::*;
  logic    valid;
  logic    ready;
  thresh_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pfmd_score.sv =====
module pfmd_score (
  input  pfmd_pkg::axis_t   avg_accel_i [3],
  input  pfmd_pkg::axis_t   avg_rate_i [3],
  input  pfmd_pkg::thresh_t threshold_i,
  output pfmd_pkg::result_t result_o
);
  import pfmd_pkg::*;

  score_t             face_score [FACE_COUNT];
  score_t             l1_score [6];
  label_t             l1_label [6];
  score_t             l2_score [3];
  label_t             l2_label [3];
  score_t             l3_score;
  label_t             l3_label;
  score_t             top_score;
  label_t             top_label;
  logic [MAG_W-1:0]   rot_sum;

  always_comb begin
    for (int i = 0; i < FACE_COUNT; i++) begin
      face_score[i] =
          SCORE_W'(scale_term(PROD_W'(FACE_CX[i]) * PROD_W'(avg_accel_i[0])))
        + SCORE_W'(scale_term(PROD_W'(FACE_CY[i]) * PROD_W'(avg_accel_i[1])))
        + SCORE_W'(scale_term(PROD_W'(FACE_CZ[i]) * PROD_W'(avg_accel_i[2])));
    end
  end

  // left side wins ties, so the earlier face is kept
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (face_score[2*i] >= face_score[2*i+1]) begin
        l1_score[i] = face_score[2*i];
        l1_label[i] = FACE_LABEL[2*i];
      end else begin
        l1_score[i] = face_score[2*i+1];
        l1_label[i] = FACE_LABEL[2*i+1];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (l1_score[2*i] >= l1_score[2*i+1]) begin
        l2_score[i] = l1_score[2*i];
        l2_label[i] = l1_label[2*i];
      end else begin
        l2_score[i] = l1_score[2*i+1];
        l2_label[i] = l1_label[2*i+1];
      end
    end
    if (l2_score[0] >= l2_score[1]) begin
      l3_score = l2_score[0];
      l3_label = l2_label[0];
    end else begin
      l3_score = l2_score[1];
      l3_label = l2_label[1];
    end
    if (l3_score >= l2_score[2]) begin
      top_score = l3_score;
      top_label = l3_label;
    end else begin
      top_score = l2_score[2];
      top_label = l2_label[2];
    end
  end

  assign rot_sum = magnitude(avg_rate_i[0]) + magnitude(avg_rate_i[1])
                 + magnitude(avg_rate_i[2]);

  always_comb begin
    if (top_score > 0) begin
      result_o.face_label = top_label;
      result_o.best_score = top_score[BEST_W-1:0];
    end else begin
      result_o.face_label = '0;
      result_o.best_score = '0;
    end
    result_o.still = (rot_sum < threshold_i);
  end

endmodule

// ===== hw/rtl/polyhedron_face_and_motion_detector.sv =====
// Channel    Dir  Payload                                       Rule
// sample_i   in   accel_x/y/z, rate_x/y/z, 16-bit signed each   valid & ready
// result_o   out  face_label 4b, best_score 16b, still 1b       valid & ready
// cfg_i      in   motion_threshold 17b                          valid & ready
//
// Two stages: the running averages register on accept, the face scores,
// face selection and still flag register into the result stage.
// One transaction per cycle sustained while result_o keeps ready high.
// Reset clears the averages to zero, the threshold to 2000 and both valids.
// A stalled result stage backs up into the average stage, which then drops ready.
`include "polyhedron_face_and_motion_detector_assert.svh"

module polyhedron_face_and_motion_detector (
  input logic           clk_i,
  input logic           rst_ni,
  pfmd_sample_if.sink   sample_i,
  pfmd_result_if.source result_o,
  pfmd_cfg_if.sink      cfg_i
);
  import pfmd_pkg::*;

  axis_t   avg_accel_q [3];
  axis_t   avg_accel_d [3];
  axis_t   avg_rate_q [3];
  axis_t   avg_rate_d [3];
  logic    avg_valid_q, avg_valid_d;
  logic    out_valid_q, out_valid_d;
  result_t out_data_q, out_data_d;
  thresh_t thresh_q, thresh_d;
  logic    in_fire;
  logic    avg_move;

  assign avg_move       = avg_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !avg_valid_q || avg_move;
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign cfg_i.ready    = 1'b1;

  always_comb begin
    avg_accel_d = avg_accel_q;
    avg_rate_d  = avg_rate_q;
    if (in_fire) begin
      avg_accel_d[0] = smooth(avg_accel_q[0], sample_i.data.accel_x);
      avg_accel_d[1] = smooth(avg_accel_q[1], sample_i.data.accel_y);
      avg_accel_d[2] = smooth(avg_accel_q[2], sample_i.data.accel_z);
      avg_rate_d[0]  = smooth(avg_rate_q[0], sample_i.data.rate_x);
      avg_rate_d[1]  = smooth(avg_rate_q[1], sample_i.data.rate_y);
      avg_rate_d[2]  = smooth(avg_rate_q[2], sample_i.data.rate_z);
    end
  end

  always_comb begin
    if (in_fire) begin
      avg_valid_d = 1'b1;
    end else if (avg_move) begin
      avg_valid_d = 1'b0;
    end else begin
      avg_valid_d = avg_valid_q;
    end
    if (avg_move) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    thresh_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.data : thresh_q;
  end

  pfmd_score u_score (
    .avg_accel_i (avg_accel_q),
    .avg_rate_i  (avg_rate_q),
    .threshold_i (thresh_q),
    .result_o    (out_data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        avg_accel_q[k] <= '0;
        avg_rate_q[k]  <= '0;
      end
      avg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      thresh_q    <= THRESH_RESET;
    end else begin
      avg_accel_q <= avg_accel_d;
      avg_rate_q  <= avg_rate_d;
      avg_valid_q <= avg_valid_d;
      out_valid_q <= out_valid_d;
      thresh_q    <= thresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  `PFMD_ASSERT(a_zero_score_label, out_valid_q && out_data_q.best_score == '0 |-> out_data_q.face_label == '0)
  `PFMD_ASSERT(a_label_range, out_valid_q |-> out_data_q.face_label < LABEL_W'(FACE_COUNT))
  `PFMD_ASSERT(a_accept_loads_avg, in_fire |=> avg_valid_q)
  `PFMD_ASSERT(a_stall_holds_avg, avg_valid_q && !avg_move |=> avg_valid_q && $stable(avg_accel_q[0]))
  `PFMD_ASSERT(a_zero_thresh_moving, out_valid_q && thresh_q == '0 |-> !out_data_q.still)
  `PFMD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_q && !avg_valid_q)

endmodule

// ===== tb/tb.sv =====
module tb;
  import pfmd_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int WEIGHT          = 8;
  localparam int SCORE_DIV       = 128;
  localparam int FACES           = 12;

  localparam int NORM_X [FACES] = '{0, 85, 26, -69, -69, 26, 69, -26, -85, -26, 69, 0};
  localparam int NORM_Y [FACES] = '{0, 0, 81, 50, -50, -81, 50, 81, 0, -81, -50, 0};
  localparam int NORM_Z [FACES] = '{100, 53, 53, 53, 53, 53, -53, -53, -53, -53, -53, -100};
  localparam label_t NORM_LABEL [FACES] = '{11, 10, 6, 7, 8, 9, 4, 5, 1, 2, 3, 0};

  logic    clk_i     = 1'b0;
  logic    rst_ni;
  logic    smp_valid = 1'b0;
  sample_t smp_data  = '0;
  logic    res_ready = 1'b0;
  logic    cfg_valid = 1'b0;
  thresh_t cfg_data  = '0;

  pfmd_sample_if smp();
  pfmd_result_if res();
  pfmd_cfg_if    cfg();

  assign smp.valid = smp_valid;
  assign smp.data  = smp_data;
  assign res.ready = res_ready;
  assign cfg.valid = cfg_valid;
  assign cfg.data  = cfg_data;

  polyhedron_face_and_motion_detector dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  sample_t pending_q[$];
  result_t expected_q[$];

  axis_t   avg_accel_m [3] = '{0, 0, 0};
  axis_t   avg_rate_m  [3] = '{0, 0, 0};
  thresh_t threshold_m     = THRESH_RESET;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        sample_taken   = 1'b0;
  logic        cfg_taken      = 1'b0;
  int          mismatches     = 0;
  int          checked        = 0;
  int          still_seen     = 0;
  int          idle_cycles    = 0;
  logic [15:0] labels_seen    = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t predict_face(input sample_t s);
    int      acc_in [3];
    int      rot_in [3];
    int      score;
    int      best;
    int      rot;
    int      a;
    result_t r;
    acc_in[0] = s.accel_x;
    acc_in[1] = s.accel_y;
    acc_in[2] = s.accel_z;
    rot_in[0] = s.rate_x;
    rot_in[1] = s.rate_y;
    rot_in[2] = s.rate_z;
    rot = 0;
    for (int k = 0; k < 3; k++) begin
      avg_accel_m[k] = axis_t'((acc_in[k] + (WEIGHT - 1) * int'(avg_accel_m[k])) / WEIGHT);
      avg_rate_m[k]  = axis_t'((rot_in[k] + (WEIGHT - 1) * int'(avg_rate_m[k])) / WEIGHT);
      a = avg_rate_m[k];
      rot += (a < 0) ? -a : a;
    end
    best = 0;
    r.face_label = '0;
    for (int i = 0; i < FACES; i++) begin
      score = (NORM_X[i] * int'(avg_accel_m[0])) / SCORE_DIV
            + (NORM_Y[i] * int'(avg_accel_m[1])) / SCORE_DIV
            + (NORM_Z[i] * int'(avg_accel_m[2])) / SCORE_DIV;
      if (score > best) begin
        best = score;
        r.face_label = NORM_LABEL[i];
      end
    end
    r.best_score = 16'(best);
    r.still = (rot < int'(threshold_m));
    return r;
  endfunction

  function automatic sample_t sample_of(int ax, int ay, int az, int rx, int ry, int rz);
    sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x  = 16'(rx);
    s.rate_y  = 16'(ry);
    s.rate_z  = 16'(rz);
    return s;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    sample_taken <= rst_ni && smp_valid && smp.ready;
    cfg_taken    <= rst_ni && cfg_valid && cfg.ready;
    if (rst_ni) begin
      if (res.valid && res_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: label %0d score %0d still %0d",
                     res.data.face_label, res.data.best_score, res.data.still);
          end
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.still) still_seen++;
          labels_seen[want.face_label] = 1'b1;
          if (res.data.face_label !== want.face_label ||
              res.data.best_score !== want.best_score ||
              res.data.still !== want.still) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected label %0d score %0d still %0d, got label %0d score %0d still %0d",
                       want.face_label, want.best_score, want.still,
                       res.data.face_label, res.data.best_score, res.data.still);
            end
          end
        end
      end
      if (smp_valid && smp.ready) begin
        expected_q.push_back(predict_face(pending_q.pop_front()));
      end
      if (cfg_valid && cfg.ready) begin
        threshold_m = cfg_data;
      end
      if ((smp_valid && smp.ready) || (res.valid && res_ready) || (cfg_valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      smp_valid <= 1'b0;
    end else if (!smp_valid || sample_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        smp_valid <= 1'b1;
        smp_data  <= pending_q[0];
      end else begin
        smp_valid <= 1'b0;
      end
    end
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_threshold(input thresh_t value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || smp_valid || expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    pending_q.push_back(sample_of(0, 0, 0, 0, 0, 0));
    // pure +y average: the two faces with equal y weight tie
    repeat (2) pending_q.push_back(sample_of(0, 32767, 0, 0, 0, 0));
    repeat (3) pending_q.push_back(sample_of(0, 0, -32768, 0, 0, 0));
    repeat (2) pending_q.push_back(sample_of(32767, 32767, 32767, 32767, 32767, 32767));
    repeat (2) pending_q.push_back(sample_of(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_q.push_back(sample_of(32767, -32768, 32767, -32768, 32767, -32768));
    pending_q.push_back(sample_of(-32768, 32767, -32768, 32767, -32768, 32767));
    pending_q.push_back(sample_of(21845, -21846, 21845, -21846, 21845, -21846));
    pending_q.push_back(sample_of(-21846, 21845, -21846, 21845, -21846, 21845));
    repeat (2) pending_q.push_back(sample_of(0, 0, 0, 0, 0, 0));
    repeat (3) pending_q.push_back(sample_of(32767, 0, 0, -32768, -32768, -32768));
    repeat (2) pending_q.push_back(sample_of(-1, -1, -1, -1, -1, -1));
  endtask

  task automatic queue_random(input int count);
    int n;
    int len;
    int face;
    int reach;
    int jitter;
    int span;
    int kind;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // hold the sensor near one face so the averages settle on it
        len    = $urandom_range(4, 30);
        if (len > count - n) len = count - n;
        face   = $urandom_range(FACES - 1);
        reach  = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(20, 326);
        jitter = $urandom_range(60);
        case ($urandom_range(3))
          0:       span = 0;
          1:       span = 63;
          2:       span = 2000;
          default: span = 32767;
        endcase
        repeat (len) begin
          pending_q.push_back(sample_of(NORM_X[face] * reach + spread(jitter),
                                        NORM_Y[face] * reach + spread(jitter),
                                        NORM_Z[face] * reach + spread(jitter),
                                        spread(span), spread(span), spread(span)));
        end
        n += len;
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 3)) begin
          pending_q.push_back(sample_of(corner_value(), corner_value(), corner_value(),
                                        corner_value(), corner_value(), corner_value()));
          n++;
        end
      end else begin
        pending_q.push_back(sample_t'({$urandom, $urandom, $urandom}));
        n++;
      end
    end
  endtask

  initial begin
    int      send_pct  [4];
    int      stall_pct [4];
    thresh_t limits    [PHASES];
    rst_ni    <= 1'b0;
    send_pct  = '{0, 70, 0, 33};
    stall_pct = '{0, 0, 70, 33};
    limits    = '{17'd0, 17'd98304, 17'd1, 17'h1FFFF, 17'd2000,
                  thresh_t'($urandom_range(98304)), 17'd500, 17'd40000};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    wait_drained();
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(limits[p]);
      send_idle_pct  = send_pct[p % 4];
      recv_stall_pct = stall_pct[p % 4];
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
    end
    repeat (4) @(negedge clk_i);
    $display("Checked %0d results over %0d threshold settings and four idling patterns",
             checked, PHASES + 1);
    $display("Face labels seen (one bit per label): %b, still reported %0d times",
             labels_seen[11:0], still_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
